>>> rtl/bchd_pkg.sv
// package: types and constants of the button click and hold detector
`default_nettype none

package bchd_pkg;

    localparam int unsigned USEC_W  = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned PRESS_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [USEC_W-1:0]  SETTLE_RESET = USEC_W'(5 * 1000);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_HIGH = 2'd0,
        CFG_SETTLE_USEC = 2'd1,
        CFG_HOLD_USEC   = 2'd2,
        CFG_CLICK_USEC  = 2'd3
    } t_cfg_idx;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SETTLE = 6'b000010,
        PH_DOWN   = 6'b000100,
        PH_HOLD   = 6'b001000,
        PH_UP     = 6'b010000,
        PH_RESET  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic               down_event;
        logic               hold_event;
        logic               release_event;
        logic               click_event;
        logic               up_event;
        logic [COUNT_W-1:0] click_count;
        logic [PRESS_W-1:0] press_number;
        logic               busy_res;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/bchd_in_if.sv
// interface: input sample channel
`default_nettype none

interface bchd_in_if
    import bchd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              pin_level;
    logic [USEC_W-1:0] now_usec;

    modport source (output valid, output pin_level, output now_usec, input ready);
    modport sink   (input valid, input pin_level, input now_usec, output ready);
endinterface

`default_nettype wire

>>> rtl/bchd_out_if.sv
// interface: result channel
`default_nettype none

interface bchd_out_if
    import bchd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               down_event;
    logic               hold_event;
    logic               release_event;
    logic               click_event;
    logic               up_event;
    logic [COUNT_W-1:0] click_count;
    logic [PRESS_W-1:0] press_number;
    logic               busy_res;

    modport source (
        output valid, output down_event, output hold_event, output release_event,
        output click_event, output up_event, output click_count, output press_number,
        output busy_res, input ready
    );
    modport sink (
        input valid, input down_event, input hold_event, input release_event,
        input click_event, input up_event, input click_count, input press_number,
        input busy_res, output ready
    );
endinterface

`default_nettype wire

>>> rtl/bchd_cfg_if.sv
// interface: configuration write channel
`default_nettype none

interface bchd_cfg_if
    import bchd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/button_click_hold_detector_top.sv
// top level: push button debounce, hold and multi-click qualifier
//
//  channel  dir  word                                   accepted when
//  i_in     in   pin_level, now_usec                    valid & ready
//  o_out    out  events, click_count, press_number, busy valid & ready
//  i_cfg    in   index, data                            valid & ready (always ready)
//
// one sample per cycle while i_in.ready is high; its result is in the output register the next cycle
// the state update is a single pass of compare logic on the 32-bit elapsed time
// i_in.ready drops only while a result waits and o_out.ready is low
// synchronous active-low reset restores register defaults and the idle phase
`default_nettype none

module button_click_hold_detector_top
    import bchd_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    bchd_in_if.sink   i_in,
    bchd_out_if.source o_out,
    bchd_cfg_if.sink  i_cfg
);

    logic              r_active_high;
    logic [USEC_W-1:0] r_settle_usec;
    logic [USEC_W-1:0] r_hold_usec;
    logic [USEC_W-1:0] r_click_usec;

    t_phase             r_phase, n_phase;
    logic [USEC_W-1:0]  r_mark, n_mark;
    logic [COUNT_W-1:0] r_clicks, n_clicks;
    logic [PRESS_W-1:0] r_cur_press, n_cur_press;
    logic [PRESS_W-1:0] r_next_press, n_next_press;
    logic               r_busy, n_busy;

    logic    r_out_valid;
    t_result r_res, n_res;

    logic              in_acc;
    logic              pressed;
    logic [USEC_W-1:0] elapsed;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;

    assign pressed = (i_in.pin_level == r_active_high);
    assign elapsed = i_in.now_usec - r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_high <= 1'b0;
            r_settle_usec <= SETTLE_RESET;
            r_hold_usec   <= '0;
            r_click_usec  <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ACTIVE_HIGH: r_active_high <= i_cfg.data[0];
                CFG_SETTLE_USEC: r_settle_usec <= i_cfg.data[USEC_W-1:0];
                CFG_HOLD_USEC:   r_hold_usec   <= i_cfg.data[USEC_W-1:0];
                CFG_CLICK_USEC:  r_click_usec  <= i_cfg.data[USEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_mark       = r_mark;
        n_clicks     = r_clicks;
        n_cur_press  = r_cur_press;
        n_next_press = r_next_press;
        n_busy       = r_busy;
        n_res        = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (pressed) begin
                    n_phase      = PH_SETTLE;
                    n_mark       = i_in.now_usec;
                    n_cur_press  = r_next_press;
                    n_next_press = r_next_press + PRESS_W'(1);
                    n_busy       = 1'b1;
                end
            end
            PH_SETTLE: begin
                if (elapsed >= r_settle_usec) begin
                    if (pressed) begin
                        n_phase          = PH_DOWN;
                        n_res.down_event = 1'b1;
                    end else begin
                        n_phase = PH_RESET;
                    end
                end
            end
            PH_DOWN: begin
                if (pressed) begin
                    if (r_hold_usec == '0) begin
                        n_busy = 1'b0;
                    end else if (elapsed >= r_hold_usec) begin
                        n_phase           = PH_HOLD;
                        n_res.hold_event  = 1'b1;
                        n_res.click_count = r_clicks;
                    end
                end else begin
                    n_phase = PH_UP;
                    n_mark  = i_in.now_usec;
                    n_busy  = 1'b1;
                end
            end
            PH_HOLD: begin
                if (pressed) begin
                    n_busy = 1'b0;
                end else begin
                    n_phase             = PH_RESET;
                    n_res.release_event = 1'b1;
                    n_res.up_event      = 1'b1;
                    n_busy              = 1'b1;
                end
            end
            PH_UP: begin
                if ((r_click_usec != '0) && pressed) begin
                    n_phase = PH_DOWN;
                    n_mark  = i_in.now_usec;
                    if (r_clicks != COUNT_MAX) begin
                        n_clicks = r_clicks + COUNT_W'(1);
                    end
                end else if ((r_click_usec == '0) || (elapsed >= r_click_usec)) begin
                    n_phase           = PH_RESET;
                    n_res.click_event = 1'b1;
                    n_res.up_event    = 1'b1;
                    n_res.click_count = r_clicks;
                end
            end
            default: begin
                n_phase     = PH_IDLE;
                n_clicks    = '0;
                n_busy      = 1'b0;
                n_cur_press = '0;
            end
        endcase

        n_res.press_number = n_cur_press;
        n_res.busy_res     = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_mark       <= '0;
            r_clicks     <= '0;
            r_cur_press  <= '0;
            r_next_press <= '0;
            r_busy       <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase      <= n_phase;
                r_mark       <= n_mark;
                r_clicks     <= n_clicks;
                r_cur_press  <= n_cur_press;
                r_next_press <= n_next_press;
                r_busy       <= n_busy;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.down_event    = r_res.down_event;
    assign o_out.hold_event    = r_res.hold_event;
    assign o_out.release_event = r_res.release_event;
    assign o_out.click_event   = r_res.click_event;
    assign o_out.up_event      = r_res.up_event;
    assign o_out.click_count   = r_res.click_count;
    assign o_out.press_number  = r_res.press_number;
    assign o_out.busy_res      = r_res.busy_res;

endmodule

`default_nettype wire

>>> sim/bchd_checker.sv
// checker: watches the button qualifier channels, predicts each result word and compares
module bchd_checker
    import bchd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    bchd_in_if   in_ch,
    bchd_out_if  out_ch,
    bchd_cfg_if  cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic               cfg_active_high;
    logic [USEC_W-1:0]  cfg_settle;
    logic [USEC_W-1:0]  cfg_hold;
    logic [USEC_W-1:0]  cfg_click;

    t_phase             btn_phase;
    logic [USEC_W-1:0]  mark_usec;
    logic [COUNT_W-1:0] click_tally;
    logic [PRESS_W-1:0] press_id;
    logic [PRESS_W-1:0] next_press_id;
    logic               busy;

    t_result            expected_reports[$];
    t_result            predicted;
    t_result            want;
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_error($sformatf("%s mismatch: got %0h, want %0h", name, got, exp_val));
        end
    endtask

    task automatic qualify_sample(input logic pin, input logic [USEC_W-1:0] now,
                                  output t_result res);
        logic              pressed;
        logic [USEC_W-1:0] elapsed;
        pressed = (pin == cfg_active_high);
        elapsed = now - mark_usec;
        res = '0;
        case (btn_phase)
            PH_IDLE: begin
                if (pressed) begin
                    btn_phase     = PH_SETTLE;
                    mark_usec     = now;
                    press_id      = next_press_id;
                    next_press_id = next_press_id + PRESS_W'(1);
                    busy          = 1'b1;
                end
            end
            PH_SETTLE: begin
                if (elapsed >= cfg_settle) begin
                    if (pressed) begin
                        btn_phase      = PH_DOWN;
                        res.down_event = 1'b1;
                    end else begin
                        btn_phase = PH_RESET;
                    end
                end
            end
            PH_DOWN: begin
                if (!pressed) begin
                    btn_phase = PH_UP;
                    mark_usec = now;
                    busy      = 1'b1;
                end else if (cfg_hold == '0) begin
                    busy = 1'b0;
                end else if (elapsed >= cfg_hold) begin
                    btn_phase       = PH_HOLD;
                    res.hold_event  = 1'b1;
                    res.click_count = click_tally;
                end
            end
            PH_HOLD: begin
                if (pressed) begin
                    busy = 1'b0;
                end else begin
                    btn_phase         = PH_RESET;
                    res.release_event = 1'b1;
                    res.up_event      = 1'b1;
                    busy              = 1'b1;
                end
            end
            PH_UP: begin
                if (cfg_click != '0 && pressed) begin
                    btn_phase = PH_DOWN;
                    if (click_tally != COUNT_MAX) begin
                        click_tally = click_tally + COUNT_W'(1);
                    end
                    mark_usec = now;
                end else if (cfg_click == '0 || elapsed >= cfg_click) begin
                    res.click_event = 1'b1;
                    res.up_event    = 1'b1;
                    res.click_count = click_tally;
                    btn_phase       = PH_RESET;
                end
            end
            default: begin
                btn_phase   = PH_IDLE;
                click_tally = '0;
                busy        = 1'b0;
                press_id    = '0;
            end
        endcase
        res.press_number = press_id;
        res.busy_res     = busy;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_active_high = 1'b0;
            cfg_settle      = SETTLE_RESET;
            cfg_hold        = '0;
            cfg_click       = '0;
            btn_phase       = PH_IDLE;
            mark_usec       = '0;
            click_tally     = '0;
            press_id        = '0;
            next_press_id   = '0;
            busy            = 1'b1;
            expected_reports.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_ACTIVE_HIGH: cfg_active_high = cfg_ch.data[0];
                    CFG_SETTLE_USEC: cfg_settle      = cfg_ch.data;
                    CFG_HOLD_USEC:   cfg_hold        = cfg_ch.data;
                    CFG_CLICK_USEC:  cfg_click       = cfg_ch.data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    report_error("result word with nothing expected");
                end else begin
                    want = expected_reports.pop_front();
                    check_field("down_event", 32'(out_ch.down_event), 32'(want.down_event));
                    check_field("hold_event", 32'(out_ch.hold_event), 32'(want.hold_event));
                    check_field("release_event", 32'(out_ch.release_event),
                                32'(want.release_event));
                    check_field("click_event", 32'(out_ch.click_event),
                                32'(want.click_event));
                    check_field("up_event", 32'(out_ch.up_event), 32'(want.up_event));
                    check_field("click_count", 32'(out_ch.click_count),
                                32'(want.click_count));
                    check_field("press_number", out_ch.press_number, want.press_number);
                    check_field("busy_res", 32'(out_ch.busy_res), 32'(want.busy_res));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                qualify_sample(in_ch.pin_level, in_ch.now_usec, predicted);
                expected_reports.push_back(predicted);
            end
        end
        o_pending <= expected_reports.size();
    end

endmodule

>>> sim/tb_button_click_hold_detector_top.sv
// testbench top: drives samples, register writes and result back-pressure, gives the verdict
module tb_button_click_hold_detector_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bchd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500_000;

    logic              i_clk;
    logic              i_rst_n;
    int                fail_total;
    int                results_due;
    int unsigned       cycle_count = 0;
    logic              press_level;
    logic [USEC_W-1:0] stamp;
    bit                steady_tail = 1'b0;
    bit                hold_off_req = 1'b0;

    bchd_in_if  in_ch ();
    bchd_out_if out_ch ();
    bchd_cfg_if cfg_ch ();

    button_click_hold_detector_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    bchd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_total),
        .o_pending    (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (!steady_tail && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    task automatic offer_sample(input logic pin, input logic [USEC_W-1:0] now);
        if (!steady_tail && $urandom_range(0, 5) == 0) begin
            in_ch.valid     <= 1'b0;
            in_ch.pin_level <= 1'($urandom);
            in_ch.now_usec  <= $urandom;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.pin_level <= pin;
        in_ch.now_usec  <= now;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_results;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic set_controls(input logic active, input logic [USEC_W-1:0] settle,
                                input logic [USEC_W-1:0] hold, input logic [USEC_W-1:0] click);
        drain_results();
        write_reg(CFG_ACTIVE_HIGH, {31'd0, active});
        write_reg(CFG_SETTLE_USEC, settle);
        write_reg(CFG_HOLD_USEC, hold);
        write_reg(CFG_CLICK_USEC, click);
        cfg_ch.valid <= 1'b0;
        press_level = active;
    endtask

    // presses and releases of random length, with bounce and timestamp jumps
    task automatic run_presses(input int count, input int max_run, input int max_step,
                               input int jump_pct, input int bounce_pct);
        int   run_left;
        bit   held;
        logic pin;
        run_left = 0;
        held     = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                held     = !held;
                run_left = $urandom_range(1, max_run);
            end
            run_left--;
            pin = held ? press_level : !press_level;
            if ($urandom_range(0, 99) < bounce_pct) begin
                pin = !pin;
            end
            if ($urandom_range(0, 99) < jump_pct) begin
                stamp = $urandom;
            end else begin
                stamp = stamp + $urandom_range(0, max_step);
            end
            offer_sample(pin, stamp);
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.pin_level  <= 1'b0;
        in_ch.now_usec   <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_ACTIVE_HIGH;
        cfg_ch.data      <= '0;
        press_level      = 1'b0;
        stamp            = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: active low, long settle, no hold, no multi-click
        offer_sample(1'b0, 32'd0);
        offer_sample(1'b0, 32'd4999);
        offer_sample(1'b0, 32'd5000);
        offer_sample(1'b0, 32'd6000);
        offer_sample(1'b1, 32'd7000);
        offer_sample(1'b1, 32'd7001);
        offer_sample(1'b1, 32'd7002);

        set_controls(1'b1, 32'd10, 32'd40, 32'd30);
        // bounce during settle across the timestamp wrap
        offer_sample(1'b1, 32'hFFFF_FFF0);
        offer_sample(1'b0, 32'hFFFF_FFF9);
        offer_sample(1'b0, 32'h0000_0005);
        // settled press, hold, release
        offer_sample(1'b1, 32'd100);
        offer_sample(1'b1, 32'd110);
        offer_sample(1'b1, 32'd139);
        offer_sample(1'b1, 32'd140);
        offer_sample(1'b1, 32'd150);
        offer_sample(1'b0, 32'd151);
        offer_sample(1'b0, 32'd152);
        // double click
        offer_sample(1'b1, 32'd200);
        offer_sample(1'b1, 32'd210);
        offer_sample(1'b0, 32'd215);
        offer_sample(1'b1, 32'd220);
        offer_sample(1'b0, 32'd225);
        offer_sample(1'b0, 32'd254);
        offer_sample(1'b0, 32'd255);
        offer_sample(1'b0, 32'd256);
        stamp = 32'd300;

        set_controls(1'b0, 32'd0, 32'd0, 32'd0);
        run_presses(150, 6, 5, 2, 5);

        set_controls(1'b1, 32'd8, 32'd25, 32'd20);
        hold_off_req = 1'b1;
        run_presses(250, 12, 4, 2, 8);

        // fast tapping inside a wide window drives the click count to saturation
        set_controls(1'b0, 32'd3, 32'd0, 32'd40);
        run_presses(600, 1, 5, 0, 0);

        set_controls(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_presses(200, 8, 5, 25, 5);

        set_controls(1'b0, 32'($urandom_range(0, 20)), 32'($urandom_range(1, 60)),
                     32'($urandom_range(1, 50)));
        run_presses(300, 15, 6, 2, 6);

        set_controls(1'b1, 32'd5, 32'd30, 32'd15);
        steady_tail = 1'b1;
        run_presses(200, 10, 4, 1, 4);

        drain_results();
        if (fail_total == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
